>>> rtl/core/brf_pkg.sv
package brf_pkg;

   localparam int unsigned DEPTH_DEFAULT = 256;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT   = 3'd0,
      KIND_GET   = 3'd1,
      KIND_PEEK  = 3'd2,
      KIND_SKIP  = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // result of one request, minus the byte that comes from the store
   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] done_count;
      logic [BYTE_W-1:0]  fill_level;
      logic [BYTE_W-1:0]  free_space;
      logic               take_data;
   } result_type;

endpackage

>>> rtl/core/byte_ring_fifo_top.sv
// Byte ring FIFO holding up to DEPTH-1 bytes in a single synchronous store.
// An accepted item waits in the pending register in write-back, then loads
// the result register on rsp_; no new item is taken before that load, which
// follows the store read. A stalled result holds up the next accepted item.
// Reset (synchronous): pointers to zero, result register empty. The store is
// not cleared; no clearing pass, the block takes items straight after reset.
module byte_ring_fifo_top #(
   parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [brf_pkg::KIND_W-1:0]  req_kind,
   input  logic [brf_pkg::BYTE_W-1:0]  req_data_in,
   input  logic [brf_pkg::BYTE_W-1:0]  req_peek_offset,
   input  logic [brf_pkg::COUNT_W-1:0] req_skip_count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [brf_pkg::BYTE_W-1:0]  rsp_data_out,
   output logic [brf_pkg::STATUS_W-1:0] rsp_status,
   output logic [brf_pkg::COUNT_W-1:0] rsp_done_count,
   output logic [brf_pkg::BYTE_W-1:0]  rsp_fill_level,
   output logic [brf_pkg::BYTE_W-1:0]  rsp_free_space
);

   localparam int unsigned AW = $clog2(DEPTH);

   // idle: take an item; write-back: merge store data into the result
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WB   = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_next;
   logic [AW-1:0] rd_ptr_next;
   logic [AW-1:0] mem_rd_addr;
   logic          mem_wr;
   logic          mem_rd;
   logic [brf_pkg::BYTE_W-1:0] mem_rd_data;

   brf_pkg::result_type result;
   brf_pkg::result_type pend_ff, pend_in;

   logic req_take;
   logic rsp_load;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [brf_pkg::BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [brf_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [brf_pkg::COUNT_W-1:0]   rsp_done_ff, rsp_done_in;
   logic [brf_pkg::BYTE_W-1:0]    rsp_fill_ff, rsp_fill_in;
   logic [brf_pkg::BYTE_W-1:0]    rsp_free_ff, rsp_free_in;

   // Decide the request against the current pointers.
   brf_ctl #(
      .DEPTH (DEPTH)
   ) u_ctl (
      .wr_ptr      (wr_ptr_ff),
      .rd_ptr      (rd_ptr_ff),
      .kind        (req_kind),
      .peek_offset (req_peek_offset),
      .skip_count  (req_skip_count),
      .wr_ptr_next (wr_ptr_next),
      .rd_ptr_next (rd_ptr_next),
      .mem_wr      (mem_wr),
      .mem_rd      (mem_rd),
      .mem_rd_addr (mem_rd_addr),
      .result      (result)
   );

   // The store sees at most one access per item, so a write and a read of the
   // same entry never meet in one cycle: the state machine is the interlock.
   brf_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_take & mem_wr),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_data_in),
      .rd_en   (req_take & mem_rd),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Take an item only when idle; the result register may still be full.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;

   // Load the result register in write-back once it is free or being drained.
   assign rsp_load = (state_ff == ST_WB) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in  = state_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      pend_in   = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // advance the pointers now; the result waits for store data
               wr_ptr_in = wr_ptr_next;
               rd_ptr_in = rd_ptr_next;
               pend_in   = result;
               state_in  = ST_WB;
            end
         end
         ST_WB: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_free_in   = rsp_free_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = pend_ff.take_data ? mem_rd_data : '0;
         rsp_status_in = pend_ff.status;
         rsp_done_in   = pend_ff.done_count;
         rsp_fill_in   = pend_ff.fill_level;
         rsp_free_in   = pend_ff.free_space;
      end else if (rsp_valid_ff & ~rsp_stall) begin
         // drop the item once it has been taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_done_count = rsp_done_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_free_space = rsp_free_ff;

endmodule

>>> rtl/core/brf_store.sv
module brf_store #(
   parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [brf_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [brf_pkg::BYTE_W-1:0] rd_data
);

   logic [brf_pkg::BYTE_W-1:0] store_ff [DEPTH];
   logic [brf_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/brf_ctl.sv
module brf_ctl #(
   parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic [AW-1:0]               wr_ptr,
   input  logic [AW-1:0]               rd_ptr,
   input  logic [brf_pkg::KIND_W-1:0]  kind,
   input  logic [brf_pkg::BYTE_W-1:0]  peek_offset,
   input  logic [brf_pkg::COUNT_W-1:0] skip_count,
   output logic [AW-1:0]               wr_ptr_next,
   output logic [AW-1:0]               rd_ptr_next,
   output logic                        mem_wr,
   output logic                        mem_rd,
   output logic [AW-1:0]               mem_rd_addr,
   output brf_pkg::result_type         result
);

   localparam int unsigned CW = (AW > brf_pkg::COUNT_W) ? AW : brf_pkg::COUNT_W;
   localparam int unsigned OW = (AW > brf_pkg::BYTE_W) ? AW : brf_pkg::BYTE_W;

   brf_pkg::kind_type   kind_e;
   brf_pkg::status_type status;
   logic [AW-1:0]       fill;
   logic [AW-1:0]       fill_next;
   logic [CW-1:0]       fill_c;
   logic [CW-1:0]       ofs_c;
   logic [CW-1:0]       cnt_c;
   logic [CW-1:0]       done_c;
   logic [CW-1:0]       peek_addr_c;
   logic [OW-1:0]       fill_o;
   logic [OW-1:0]       free_o;

   assign kind_e      = brf_pkg::kind_type'(kind);
   assign fill        = wr_ptr - rd_ptr;
   assign fill_c      = CW'(fill);
   assign ofs_c       = CW'(peek_offset);
   assign cnt_c       = CW'(skip_count);
   assign peek_addr_c = CW'(rd_ptr) + ofs_c;

   always_comb begin
      wr_ptr_next = wr_ptr;
      rd_ptr_next = rd_ptr;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      mem_rd_addr = rd_ptr;
      status      = brf_pkg::STATUS_OK;
      done_c      = '0;
      unique case (kind_e)
         brf_pkg::KIND_PUT: begin
            if (&fill) begin
               status = brf_pkg::STATUS_FULL;
            end else begin
               mem_wr      = 1'b1;
               wr_ptr_next = wr_ptr + AW'(1);
            end
         end
         brf_pkg::KIND_GET: begin
            if (fill == '0) begin
               status = brf_pkg::STATUS_EMPTY;
            end else begin
               mem_rd      = 1'b1;
               rd_ptr_next = rd_ptr + AW'(1);
            end
         end
         brf_pkg::KIND_PEEK: begin
            if (ofs_c >= fill_c) begin
               status = brf_pkg::STATUS_EMPTY;
            end else begin
               mem_rd      = 1'b1;
               mem_rd_addr = peek_addr_c[AW-1:0];
            end
         end
         brf_pkg::KIND_SKIP: begin
            done_c      = (cnt_c > fill_c) ? fill_c : cnt_c;
            rd_ptr_next = rd_ptr + done_c[AW-1:0];
         end
         brf_pkg::KIND_CLEAR: begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
         end
         default: begin
         end
      endcase
   end

   // free space is the all-ones count minus the fill
   assign fill_next = wr_ptr_next - rd_ptr_next;
   assign fill_o    = OW'(fill_next);
   assign free_o    = OW'(~fill_next);

   always_comb begin
      result            = '0;
      result.status     = status;
      result.done_count = done_c[brf_pkg::COUNT_W-1:0];
      result.fill_level = fill_o[brf_pkg::BYTE_W-1:0];
      result.free_space = free_o[brf_pkg::BYTE_W-1:0];
      result.take_data  = mem_rd;
   end

endmodule

>>> rtl/core/brf_checker.sv
module brf_checker #(
   parameter int unsigned DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [brf_pkg::BYTE_W-1:0]   rsp_data_out,
   input logic [brf_pkg::STATUS_W-1:0] rsp_status,
   input logic [brf_pkg::COUNT_W-1:0]  rsp_done_count,
   input logic [brf_pkg::BYTE_W-1:0]   rsp_fill_level,
   input logic [brf_pkg::BYTE_W-1:0]   rsp_free_space
);

   localparam logic [brf_pkg::BYTE_W-1:0] SUM_LOW = brf_pkg::BYTE_W'(DEPTH - 1);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_fill_level))
      else $error("stalled result changed");

   // one item at a time: an accepted item closes the input in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in flight");

   // fill and free always add up to the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> brf_pkg::BYTE_W'(rsp_fill_level + rsp_free_space) == SUM_LOW)
      else $error("fill and free disagree");

   // a dropped byte means no free space
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brf_pkg::STATUS_FULL |-> rsp_free_space == '0
         && rsp_data_out == '0)
      else $error("full reported with free space");

   // an empty report carries no byte and no discard
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == brf_pkg::STATUS_EMPTY |-> rsp_data_out == '0
         && rsp_done_count == '0)
      else $error("empty result carries data");

endmodule

bind byte_ring_fifo_top brf_checker #(
   .DEPTH (DEPTH)
) u_brf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_data_out    (rsp_data_out),
   .rsp_status      (rsp_status),
   .rsp_done_count  (rsp_done_count),
   .rsp_fill_level  (rsp_fill_level),
   .rsp_free_space  (rsp_free_space)
);
